// ----- rtl/lobm_pkg.sv -----
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types, codes and defaults of the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int SYMBOLS_DEF = 4;
    localparam int ORDERS_DEF  = 32;

    // Request operation codes
    localparam logic [1:0] OP_BUY    = 2'd0;
    localparam logic [1:0] OP_SELL   = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_BAD    = 2'd3;

    // Request status codes
    localparam logic [2:0] ST_CREATED   = 3'd0;
    localparam logic [2:0] ST_CANCELLED = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_UNRECOG   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // Result item kinds
    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  symbol;
        logic [15:0] trader_id;
        logic [23:0] limit_price;
        logic [15:0] quantity;
        logic [31:0] cancel_handle;
    } req_t;

    typedef struct packed {
        logic        item_kind;
        logic [2:0]  status;
        logic [31:0] new_handle;
        logic [23:0] trade_price;
        logic [15:0] trade_quantity;
        logic [31:0] buy_handle;
        logic [31:0] sell_handle;
        logic [15:0] buyer;
        logic [15:0] seller;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [23:0] price;
        logic [15:0] quantity;
        logic [15:0] trader;
        logic [31:0] handle;
    } entry_t;

endpackage

// ----- rtl/lobm_req_if.sv -----
// ----------------------------------------------------------------------------
// lobm_req_if
// Request channel: valid/ready handshake with one request per transfer.
// ----------------------------------------------------------------------------
interface lobm_req_if;
    logic            valid;
    logic            ready;
    lobm_pkg::req_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/lobm_res_if.sv -----
// ----------------------------------------------------------------------------
// lobm_res_if
// Result channel: valid/ready handshake with one result item per transfer.
// ----------------------------------------------------------------------------
interface lobm_res_if;
    logic            valid;
    logic            ready;
    lobm_pkg::res_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/limit_order_book_matcher.sv -----
// Sequence: a new order is written to the lowest free slot of its side; each fill is then a
//   scan of both sides, a decision and two write-backs, and a final scan with no cross leads to
//   the status item. A cancel scans the sell side, then the buy side, then emits its status.
// Throughput: one request at a time; the scan of the order memory, one entry per cycle on its
//   single read port, sets the rate.
// Reset: all books empty, handle counter zero; order memory contents stay undefined.
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority matcher over per-symbol buy and sell books held in one
// synchronous order memory, with a valid bit per entry in flip-flops.
// ----------------------------------------------------------------------------
module limit_order_book_matcher #(
    parameter int SYMBOLS         = lobm_pkg::SYMBOLS_DEF,
    parameter int ORDERS_PER_SIDE = lobm_pkg::ORDERS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lobm_req_if.sink      req,
    lobm_res_if.source    res
);

    localparam int ENTRIES = SYMBOLS * 2 * ORDERS_PER_SIDE;
    localparam int EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SPAN    = 2 * ORDERS_PER_SIDE;
    localparam int CW      = $clog2(SPAN + 1);
    localparam int FW      = $clog2(ORDERS_PER_SIDE + 1);
    localparam logic [CW-1:0] SPAN_C = CW'(SPAN);
    localparam logic [CW-1:0] HALF_C = CW'(ORDERS_PER_SIDE);
    localparam logic [FW-1:0] FMAX_C = FW'(ORDERS_PER_SIDE);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_NEW    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_WB_B   = 3'd4;
    localparam logic [2:0] S_WB_S   = 3'd5;
    localparam logic [2:0] S_CSCAN  = 3'd6;
    localparam logic [2:0] S_STATUS = 3'd7;

    // Order memory
    lobm_pkg::entry_t mem [ENTRIES];

    logic [2:0]             state_reg,    state_next;
    lobm_pkg::req_t         req_reg,      req_next;
    logic [ENTRIES-1:0]     valid_reg;
    logic [31:0]            handle_reg,   handle_next;
    logic [CW-1:0]          cnt_reg,      cnt_next;
    logic [FW-1:0]          fills_reg,    fills_next;
    logic                   rd_pend_reg,  rd_pend_next;
    logic                   rd_vld_reg,   rd_vld_next;
    logic                   rd_sell_reg,  rd_sell_next;
    logic [EW-1:0]          rd_idx_reg,   rd_idx_next;
    lobm_pkg::entry_t       rdata_reg;
    logic                   b_have_reg,   b_have_next;
    logic [EW-1:0]          b_idx_reg,    b_idx_next;
    lobm_pkg::entry_t       b_ent_reg,    b_ent_next;
    logic                   s_have_reg,   s_have_next;
    logic [EW-1:0]          s_idx_reg,    s_idx_next;
    lobm_pkg::entry_t       s_ent_reg,    s_ent_next;
    logic [2:0]             status_reg,   status_next;
    logic [31:0]            nh_reg,       nh_next;
    logic                   out_vld_reg,  out_vld_next;
    lobm_pkg::res_t         out_reg,      out_next;

    logic                   mem_re, mem_we;
    logic [EW-1:0]          mem_raddr, mem_waddr;
    lobm_pkg::entry_t       mem_wdata;
    logic                   v_we, v_val;
    logic [EW-1:0]          v_idx;

    logic [EW-1:0]          base;
    logic [EW-1:0]          side_base;
    logic                   free_found;
    logic [EW-1:0]          free_idx;
    logic [CW-1:0]          cofs;
    logic                   slot_free;
    logic [15:0]            fill_q;

    // Book bases of the held request
    assign base      = EW'(32'(req_reg.symbol) * SPAN);
    assign side_base = (req_reg.operation == lobm_pkg::OP_SELL)
                       ? base + EW'(ORDERS_PER_SIDE) : base;
    assign slot_free = !out_vld_reg || res.ready;
    assign fill_q    = (s_ent_reg.quantity < b_ent_reg.quantity)
                       ? s_ent_reg.quantity : b_ent_reg.quantity;
    // Cancel visits the sell side first, then the buy side
    assign cofs      = (cnt_reg < HALF_C) ? cnt_reg + HALF_C : cnt_reg - HALF_C;

    assign req.ready = (state_reg == S_IDLE);
    assign res.valid = out_vld_reg;
    assign res.data  = out_reg;

    // Find the lowest free slot of the side
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = side_base;
        for (int i = ORDERS_PER_SIDE - 1; i >= 0; i--)
        begin
            if (!valid_reg[side_base + EW'(i)])
            begin
                free_found = 1'b1;
                free_idx   = side_base + EW'(i);
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        handle_next  = handle_reg;
        cnt_next     = cnt_reg;
        fills_next   = fills_reg;
        rd_pend_next = 1'b0;
        rd_vld_next  = rd_vld_reg;
        rd_sell_next = rd_sell_reg;
        rd_idx_next  = rd_idx_reg;
        b_have_next  = b_have_reg;
        b_idx_next   = b_idx_reg;
        b_ent_next   = b_ent_reg;
        s_have_next  = s_have_reg;
        s_idx_next   = s_idx_reg;
        s_ent_next   = s_ent_reg;
        status_next  = status_reg;
        nh_next      = nh_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !res.ready;
        mem_re       = 1'b0;
        mem_raddr    = base + EW'(cnt_reg);
        mem_we       = 1'b0;
        mem_waddr    = free_idx;
        mem_wdata    = b_ent_reg;
        v_we         = 1'b0;
        v_val        = 1'b0;
        v_idx        = free_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next = req.data;
                    nh_next  = '0;
                    if (req.data.operation == lobm_pkg::OP_BAD
                        || 32'(req.data.symbol) >= SYMBOLS)
                    begin
                        status_next = lobm_pkg::ST_UNRECOG;
                        state_next  = S_STATUS;
                    end
                    else if (req.data.operation == lobm_pkg::OP_CANCEL)
                    begin
                        cnt_next   = '0;
                        state_next = S_CSCAN;
                    end
                    else
                    begin
                        state_next = S_NEW;
                    end
                end
            end

            S_NEW:
            begin
                if (!free_found)
                begin
                    status_next = lobm_pkg::ST_FULL;
                    state_next  = S_STATUS;
                end
                else
                begin
                    mem_we             = 1'b1;
                    mem_waddr          = free_idx;
                    mem_wdata.price    = req_reg.limit_price;
                    mem_wdata.quantity = req_reg.quantity;
                    mem_wdata.trader   = req_reg.trader_id;
                    mem_wdata.handle   = handle_reg;
                    v_we               = 1'b1;
                    v_val              = 1'b1;
                    v_idx              = free_idx;
                    nh_next            = handle_reg;
                    handle_next        = handle_reg + 32'd1;
                    status_next        = lobm_pkg::ST_CREATED;
                    fills_next         = '0;
                    cnt_next           = '0;
                    b_have_next        = 1'b0;
                    s_have_next        = 1'b0;
                    state_next         = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle over both sides
                if (cnt_reg < SPAN_C)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = base + EW'(cnt_reg);
                    rd_pend_next = 1'b1;
                    rd_vld_next  = valid_reg[base + EW'(cnt_reg)];
                    rd_sell_next = (cnt_reg >= HALF_C);
                    rd_idx_next  = base + EW'(cnt_reg);
                    cnt_next     = cnt_reg + CW'(1);
                end
                // Track the best order of each side
                if (rd_pend_reg && rd_vld_reg)
                begin
                    if (!rd_sell_reg)
                    begin
                        if (!b_have_reg || rdata_reg.price > b_ent_reg.price
                            || (rdata_reg.price == b_ent_reg.price
                                && rdata_reg.handle < b_ent_reg.handle))
                        begin
                            b_have_next = 1'b1;
                            b_idx_next  = rd_idx_reg;
                            b_ent_next  = rdata_reg;
                        end
                    end
                    else
                    begin
                        if (!s_have_reg || rdata_reg.price < s_ent_reg.price
                            || (rdata_reg.price == s_ent_reg.price
                                && rdata_reg.handle < s_ent_reg.handle))
                        begin
                            s_have_next = 1'b1;
                            s_idx_next  = rd_idx_reg;
                            s_ent_next  = rdata_reg;
                        end
                    end
                end
                if (cnt_reg == SPAN_C && !rd_pend_reg)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (!b_have_reg || !s_have_reg || s_ent_reg.price > b_ent_reg.price)
                begin
                    state_next = S_STATUS;
                end
                else if (slot_free)
                begin
                    // Emit the fill at the price of the earlier order
                    out_vld_next           = 1'b1;
                    out_next.item_kind     = lobm_pkg::KIND_TRADE;
                    out_next.status        = lobm_pkg::ST_CREATED;
                    out_next.new_handle    = '0;
                    out_next.trade_price   = (s_ent_reg.handle < b_ent_reg.handle)
                                             ? s_ent_reg.price : b_ent_reg.price;
                    out_next.trade_quantity = fill_q;
                    out_next.buy_handle    = b_ent_reg.handle;
                    out_next.sell_handle   = s_ent_reg.handle;
                    out_next.buyer         = b_ent_reg.trader;
                    out_next.seller        = s_ent_reg.trader;
                    out_next.last          = 1'b0;
                    b_ent_next.quantity    = b_ent_reg.quantity - fill_q;
                    s_ent_next.quantity    = s_ent_reg.quantity - fill_q;
                    state_next             = S_WB_B;
                end
            end

            S_WB_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = b_idx_reg;
                mem_wdata = b_ent_reg;
                if (b_ent_reg.quantity == 16'd0)
                begin
                    v_we  = 1'b1;
                    v_val = 1'b0;
                    v_idx = b_idx_reg;
                end
                state_next = S_WB_S;
            end

            S_WB_S:
            begin
                mem_we    = 1'b1;
                mem_waddr = s_idx_reg;
                mem_wdata = s_ent_reg;
                if (s_ent_reg.quantity == 16'd0)
                begin
                    v_we  = 1'b1;
                    v_val = 1'b0;
                    v_idx = s_idx_reg;
                end
                fills_next  = fills_reg + FW'(1);
                cnt_next    = '0;
                b_have_next = 1'b0;
                s_have_next = 1'b0;
                if (fills_reg + FW'(1) == FMAX_C)
                begin
                    state_next = S_STATUS;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_CSCAN:
            begin
                if (rd_pend_reg && rd_vld_reg && rdata_reg.handle == req_reg.cancel_handle)
                begin
                    // Drop the first match
                    v_we        = 1'b1;
                    v_val       = 1'b0;
                    v_idx       = rd_idx_reg;
                    status_next = lobm_pkg::ST_CANCELLED;
                    state_next  = S_STATUS;
                end
                else
                begin
                    if (cnt_reg < SPAN_C)
                    begin
                        mem_re       = 1'b1;
                        mem_raddr    = base + EW'(cofs);
                        rd_pend_next = 1'b1;
                        rd_vld_next  = valid_reg[base + EW'(cofs)];
                        rd_idx_next  = base + EW'(cofs);
                        cnt_next     = cnt_reg + CW'(1);
                    end
                    else if (!rd_pend_reg)
                    begin
                        status_next = lobm_pkg::ST_NOT_FOUND;
                        state_next  = S_STATUS;
                    end
                end
            end

            S_STATUS:
            begin
                if (slot_free)
                begin
                    out_vld_next            = 1'b1;
                    out_next.item_kind      = lobm_pkg::KIND_STATUS;
                    out_next.status         = status_reg;
                    out_next.new_handle     = nh_reg;
                    out_next.trade_price    = '0;
                    out_next.trade_quantity = '0;
                    out_next.buy_handle     = '0;
                    out_next.sell_handle    = '0;
                    out_next.buyer          = '0;
                    out_next.seller         = '0;
                    out_next.last           = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Order memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            handle_reg  <= '0;
            rd_pend_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            handle_reg  <= handle_next;
            rd_pend_reg <= rd_pend_next;
            out_vld_reg <= out_vld_next;
            if (v_we)
            begin
                valid_reg[v_idx] <= v_val;
            end
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        cnt_reg     <= cnt_next;
        fills_reg   <= fills_next;
        rd_vld_reg  <= rd_vld_next;
        rd_sell_reg <= rd_sell_next;
        rd_idx_reg  <= rd_idx_next;
        b_have_reg  <= b_have_next;
        b_idx_reg   <= b_idx_next;
        b_ent_reg   <= b_ent_next;
        s_have_reg  <= s_have_next;
        s_idx_reg   <= s_idx_next;
        s_ent_reg   <= s_ent_next;
        status_reg  <= status_next;
        nh_reg      <= nh_next;
        out_reg     <= out_next;
    end

endmodule
